@@ hdl/nnd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared types and constants for the nearest neighbor downscaler: field
// widths, fixed-point format and configuration register indexes.
// ----------------------------------------------------------------------------
package nnd_pkg;

	// default largest source dimension
	localparam int MAX_DIM_DEF = 4096;

	// payload field widths
	localparam int PIX_W   = 16;
	localparam int COORD_W = 12;

	// configuration register widths
	localparam int REG_W  = 13;
	localparam int STEP_W = 29;
	localparam int FRAC_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// fixed-point limits
	localparam logic [STEP_W-1:0] ACC_MAX = {STEP_W{1'b1}};
	localparam logic [STEP_W-1:0] ONE_Q16 = STEP_W'(32'h0001_0000);

	// register reset values
	localparam logic [REG_W-1:0]  SIZE_RST = REG_W'(1);
	localparam logic [STEP_W-1:0] STEP_RST = ONE_Q16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_TARGET_WIDTH  = 3'd2,
		REG_TARGET_HEIGHT = 3'd3,
		REG_COLUMN_STEP   = 3'd4,
		REG_ROW_STEP      = 3'd5
	} cfg_reg_t;

endpackage
`default_nettype wire

@@ hdl/nnd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnd_if
// Valid/ready channel interfaces of the downscaler: source pixel stream,
// kept pixel stream and configuration write channel.
// ----------------------------------------------------------------------------

// source pixel stream
interface nnd_in_if;
	logic                       valid;
	logic                       ready;
	logic [nnd_pkg::PIX_W-1:0]  pixel_in;
	logic                       frame_start;

	modport source (output valid, pixel_in, frame_start, input ready);
	modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

// kept pixel stream
interface nnd_out_if;
	logic                         valid;
	logic                         ready;
	logic [nnd_pkg::PIX_W-1:0]    pixel_out;
	logic [nnd_pkg::COORD_W-1:0]  dest_column;
	logic [nnd_pkg::COORD_W-1:0]  dest_row;
	logic                         row_end;
	logic                         frame_end;

	modport source (output valid, pixel_out, dest_column, dest_row, row_end, frame_end,
		input ready);
	modport sink   (input valid, pixel_out, dest_column, dest_row, row_end, frame_end,
		output ready);
endinterface

// configuration write channel
interface nnd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nnd_pkg::CFG_IDX_W-1:0]   index;
	logic [nnd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/nearest_neighbor_downscaler.sv @@
// Path: a kept pixel passes the input beat register and the output register before pix_out.
// Throughput: one source pixel per cycle while pix_out is not stalled; the position and accumulator update
// is a single pass of adds and compares in the stage-one register loop.
// Reset: arst_n clears all position state and valid flags, sets the sizes
// to 1 and both steps to 1.0; configuration writes are taken every cycle.
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Streaming nearest neighbor decimator. Keeps the source pixel at column
// floor(dx*column_step) and row floor(dy*row_step) for each destination
// pixel, tagging it with destination coordinates and end marks.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler #(
	parameter int MAX_DIM = nnd_pkg::MAX_DIM_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	nnd_in_if.sink       pix_in,
	nnd_out_if.source    pix_out,
	nnd_cfg_if.sink      cfg
);

	localparam int CW = $clog2(MAX_DIM);   // source counters
	localparam int DW = CW + 1;            // destination counters reach the target size
	localparam int SW = nnd_pkg::STEP_W;
	localparam int RW = nnd_pkg::REG_W;
	localparam int FW = nnd_pkg::FRAC_W;

	// configuration registers
	logic [RW-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [SW-1:0] col_step_q, row_step_q;

	// position state
	logic [CW-1:0] src_col_q, src_row_q;
	logic [DW-1:0] dst_col_q, dst_row_q;
	logic [SW-1:0] col_acc_q, row_acc_q;

	// input stage
	logic                       valid_s1;
	logic [nnd_pkg::PIX_W-1:0]  pixel_s1;
	logic                       frame_start_s1;

	// output register
	logic                         out_valid_q;
	logic [nnd_pkg::PIX_W-1:0]    out_pixel_q;
	logic [nnd_pkg::COORD_W-1:0]  out_col_q, out_row_q;
	logic                         out_row_end_q, out_frame_end_q;

	// stage control
	logic adv_s1;
	logic take_in;

	// effective state after frame start clearing
	logic [CW-1:0] e_src_col, e_src_row;
	logic [DW-1:0] e_dst_col, e_dst_row;
	logic [SW-1:0] e_col_acc, e_row_acc;

	// per-pixel decisions
	logic          geo_ok;
	logic          row_sel, col_sel, keep;
	logic          row_end, frame_end;
	logic          col_last, row_last;
	logic [SW:0]   col_sum, row_sum;
	logic [SW-1:0] col_acc_add, row_acc_add;

	// next state
	logic [CW-1:0] n_src_col, n_src_row;
	logic [DW-1:0] n_dst_col, n_dst_row;
	logic [SW-1:0] n_col_acc, n_row_acc;

	// handshake
	assign adv_s1       = !out_valid_q || pix_out.ready;
	assign pix_in.ready = !valid_s1 || adv_s1;
	assign take_in      = pix_in.valid && pix_in.ready;
	assign cfg.ready    = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q    <= nnd_pkg::SIZE_RST;
			src_h_q    <= nnd_pkg::SIZE_RST;
			tgt_w_q    <= nnd_pkg::SIZE_RST;
			tgt_h_q    <= nnd_pkg::SIZE_RST;
			col_step_q <= nnd_pkg::STEP_RST;
			row_step_q <= nnd_pkg::STEP_RST;
		end else if (cfg.valid) begin
			case (nnd_pkg::cfg_reg_t'(cfg.index))
				nnd_pkg::REG_SOURCE_WIDTH:  src_w_q    <= cfg.data[RW-1:0];
				nnd_pkg::REG_SOURCE_HEIGHT: src_h_q    <= cfg.data[RW-1:0];
				nnd_pkg::REG_TARGET_WIDTH:  tgt_w_q    <= cfg.data[RW-1:0];
				nnd_pkg::REG_TARGET_HEIGHT: tgt_h_q    <= cfg.data[RW-1:0];
				nnd_pkg::REG_COLUMN_STEP:   col_step_q <= cfg.data[SW-1:0];
				nnd_pkg::REG_ROW_STEP:      row_step_q <= cfg.data[SW-1:0];
				default: ;
			endcase
		end
	end

	// geometry check: non-empty, within limits, shrinking only
	always_comb begin
		geo_ok = (src_w_q != '0) && (src_h_q != '0) && (tgt_w_q != '0) && (tgt_h_q != '0)
			&& (32'(src_w_q) <= 32'(MAX_DIM)) && (32'(src_h_q) <= 32'(MAX_DIM))
			&& (tgt_w_q <= src_w_q) && (tgt_h_q <= src_h_q)
			&& (col_step_q >= nnd_pkg::ONE_Q16) && (row_step_q >= nnd_pkg::ONE_Q16);
	end

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pixel_s1       <= pix_in.pixel_in;
			frame_start_s1 <= pix_in.frame_start;
		end
	end

	// frame start clears position before this pixel
	always_comb begin
		if (frame_start_s1) begin
			e_src_col = '0;
			e_src_row = '0;
			e_dst_col = '0;
			e_dst_row = '0;
			e_col_acc = '0;
			e_row_acc = '0;
		end else begin
			e_src_col = src_col_q;
			e_src_row = src_row_q;
			e_dst_col = dst_col_q;
			e_dst_row = dst_row_q;
			e_col_acc = col_acc_q;
			e_row_acc = row_acc_q;
		end
	end

	// selection and end marks
	always_comb begin
		row_sel   = (32'(e_dst_row) < 32'(tgt_h_q))
			&& (32'(e_src_row) == 32'(e_row_acc[SW-1:FW]));
		col_sel   = (32'(e_dst_col) < 32'(tgt_w_q))
			&& (32'(e_src_col) == 32'(e_col_acc[SW-1:FW]));
		keep      = geo_ok && row_sel && col_sel;
		row_end   = (32'(e_dst_col) + 32'd1) == 32'(tgt_w_q);
		frame_end = row_end && ((32'(e_dst_row) + 32'd1) == 32'(tgt_h_q));
		col_last  = (32'(e_src_col) + 32'd1) >= 32'(src_w_q);
		row_last  = (32'(e_src_row) + 32'd1) >= 32'(src_h_q);
	end

	// saturating accumulator advance
	always_comb begin
		col_sum     = {1'b0, e_col_acc} + {1'b0, col_step_q};
		row_sum     = {1'b0, e_row_acc} + {1'b0, row_step_q};
		col_acc_add = col_sum[SW] ? nnd_pkg::ACC_MAX : col_sum[SW-1:0];
		row_acc_add = row_sum[SW] ? nnd_pkg::ACC_MAX : row_sum[SW-1:0];
	end

	// next position state
	always_comb begin
		n_src_col = e_src_col;
		n_src_row = e_src_row;
		n_dst_col = e_dst_col;
		n_dst_row = e_dst_row;
		n_col_acc = e_col_acc;
		n_row_acc = e_row_acc;
		if (geo_ok) begin
			if (col_sel) begin
				n_dst_col = e_dst_col + 1'b1;
				n_col_acc = col_acc_add;
			end
			if (col_last) begin
				n_src_col = '0;
				n_dst_col = '0;
				n_col_acc = '0;
				if (row_last) begin
					n_src_row = '0;
					n_dst_row = '0;
					n_row_acc = '0;
				end else begin
					n_src_row = e_src_row + 1'b1;
					if (row_sel) begin
						n_dst_row = e_dst_row + 1'b1;
						n_row_acc = row_acc_add;
					end
				end
			end else begin
				n_src_col = e_src_col + 1'b1;
			end
		end
	end

	// position state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			col_acc_q <= '0;
			row_acc_q <= '0;
		end else if (valid_s1 && adv_s1) begin
			src_col_q <= n_src_col;
			src_row_q <= n_src_row;
			dst_col_q <= n_dst_col;
			dst_row_q <= n_dst_row;
			col_acc_q <= n_col_acc;
			row_acc_q <= n_row_acc;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1 && keep;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && keep) begin
			out_pixel_q     <= pixel_s1;
			out_col_q       <= nnd_pkg::COORD_W'(e_dst_col);
			out_row_q       <= nnd_pkg::COORD_W'(e_dst_row);
			out_row_end_q   <= row_end;
			out_frame_end_q <= frame_end;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel_out   = out_pixel_q;
	assign pix_out.dest_column = out_col_q;
	assign pix_out.dest_row    = out_row_q;
	assign pix_out.row_end     = out_row_end_q;
	assign pix_out.frame_end   = out_frame_end_q;

`ifndef ASSERT_OFF
	// end of frame is always also end of row
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_frame_end_q || out_row_end_q))
		else $error("frame_end without row_end");

	// a kept column lies inside the destination width
	a_col_in_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(out_col_q) < 32'(tgt_w_q)))
		else $error("dest_column beyond target width");

	// bad geometry leaves the source position frozen
	a_bad_geo_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && !geo_ok && !frame_start_s1)
		|=> ($stable(src_col_q) && $stable(src_row_q) && !out_valid_q))
		else $error("position moved under invalid geometry");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest neighbor downscaler. A directed table
// covers reset state, extreme sizes and steps, far targets, rejected geometry,
// masked and unknown register writes. Random frames over many geometries
// follow. Every kept pixel beat is checked against a behavioral scaler or a typed
// table entry, under random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	// run sizing
	localparam int RAND_ITEMS   = 700;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 100;

	// register indexes with no register behind them
	localparam logic [nnd_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [nnd_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [nnd_pkg::PIX_W-1:0]   pixel;
		logic [nnd_pkg::COORD_W-1:0] col;
		logic [nnd_pkg::COORD_W-1:0] row;
		logic                        row_end;
		logic                        frame_end;
	} kept_pixel_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_mode_t;
	typedef enum int {SHAPE_NORMAL, SHAPE_FULL, SHAPE_WIDE, SHAPE_BAD} shape_t;

	typedef struct {
		row_kind_t                      kind;
		logic [nnd_pkg::CFG_IDX_W-1:0]  idx;
		logic [nnd_pkg::CFG_DATA_W-1:0] data;
		logic [nnd_pkg::PIX_W-1:0]      pix;
		logic                           fs;
		chk_mode_t                      chk;
		kept_pixel_t                    res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	nnd_in_if  src_bus ();
	nnd_out_if dst_bus ();
	nnd_cfg_if cfg_bus ();

	nearest_neighbor_downscaler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (src_bus),
		.pix_out(dst_bus),
		.cfg    (cfg_bus)
	);

	// scaler geometry, mirrored from register writes
	logic [nnd_pkg::REG_W-1:0]  src_w = nnd_pkg::SIZE_RST;
	logic [nnd_pkg::REG_W-1:0]  src_h = nnd_pkg::SIZE_RST;
	logic [nnd_pkg::REG_W-1:0]  dst_w = nnd_pkg::SIZE_RST;
	logic [nnd_pkg::REG_W-1:0]  dst_h = nnd_pkg::SIZE_RST;
	logic [nnd_pkg::STEP_W-1:0] col_step = nnd_pkg::STEP_RST;
	logic [nnd_pkg::STEP_W-1:0] row_step = nnd_pkg::STEP_RST;

	// scan position: next source pixel, next kept column and row
	logic [nnd_pkg::REG_W-1:0]  pos_col = '0;
	logic [nnd_pkg::REG_W-1:0]  pos_row = '0;
	logic [nnd_pkg::STEP_W-1:0] col_phase = '0;
	logic [nnd_pkg::STEP_W-1:0] row_phase = '0;
	logic [nnd_pkg::REG_W-1:0]  out_col = '0;
	logic [nnd_pkg::REG_W-1:0]  out_row = '0;

	kept_pixel_t kept_q[$];
	int          err_cnt = 0;
	int          cycle_cnt = 0;

	// what the offered source beat should produce
	chk_mode_t   offer_chk = CHK_MODEL;
	kept_pixel_t offer_res = '0;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	stim_row_t dir_rows[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic flag(input string msg);
		if (err_cnt < MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic void clear_position();
		pos_col = '0;
		pos_row = '0;
		col_phase = '0;
		row_phase = '0;
		out_col = '0;
		out_row = '0;
	endfunction

	function automatic logic [nnd_pkg::STEP_W-1:0] sat_add(
		input logic [nnd_pkg::STEP_W-1:0] a, input logic [nnd_pkg::STEP_W-1:0] b);
		logic [nnd_pkg::STEP_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, nnd_pkg::ACC_MAX}) ? nnd_pkg::ACC_MAX : s[nnd_pkg::STEP_W-1:0];
	endfunction

	function automatic bit geometry_ok();
		if (src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0) return 1'b0;
		if (src_w > nnd_pkg::MAX_DIM_DEF || src_h > nnd_pkg::MAX_DIM_DEF) return 1'b0;
		if (dst_w > src_w || dst_h > src_h) return 1'b0;
		if (col_step < nnd_pkg::ONE_Q16 || row_step < nnd_pkg::ONE_Q16) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [nnd_pkg::CFG_IDX_W-1:0] idx,
		input logic [nnd_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			nnd_pkg::REG_SOURCE_WIDTH:  src_w = data[nnd_pkg::REG_W-1:0];
			nnd_pkg::REG_SOURCE_HEIGHT: src_h = data[nnd_pkg::REG_W-1:0];
			nnd_pkg::REG_TARGET_WIDTH:  dst_w = data[nnd_pkg::REG_W-1:0];
			nnd_pkg::REG_TARGET_HEIGHT: dst_h = data[nnd_pkg::REG_W-1:0];
			nnd_pkg::REG_COLUMN_STEP:   col_step = data[nnd_pkg::STEP_W-1:0];
			nnd_pkg::REG_ROW_STEP:      row_step = data[nnd_pkg::STEP_W-1:0];
			default: ;
		endcase
	endfunction

	// advance the scan by one source pixel, return the kept pixel if any
	task automatic decimate(input logic [nnd_pkg::PIX_W-1:0] pix, input logic fs,
		output bit hit, output kept_pixel_t res);
		bit row_sel;
		bit col_sel;
		hit = 1'b0;
		res = '0;
		if (fs) clear_position();
		if (!geometry_ok()) return;

		row_sel = (out_row < dst_h)
			&& (pos_row == row_phase[nnd_pkg::STEP_W-1:nnd_pkg::FRAC_W]);
		col_sel = (out_col < dst_w)
			&& (pos_col == col_phase[nnd_pkg::STEP_W-1:nnd_pkg::FRAC_W]);

		if (row_sel && col_sel) begin
			hit = 1'b1;
			res.pixel = pix;
			res.col = out_col[nnd_pkg::COORD_W-1:0];
			res.row = out_row[nnd_pkg::COORD_W-1:0];
			res.row_end = (out_col + 13'd1 == dst_w);
			res.frame_end = res.row_end && (out_row + 13'd1 == dst_h);
		end

		if (col_sel) begin
			out_col++;
			col_phase = sat_add(col_phase, col_step);
		end

		// end of source row, end of source frame
		if (pos_col + 13'd1 >= src_w) begin
			pos_col = '0;
			col_phase = '0;
			out_col = '0;
			if (pos_row + 13'd1 >= src_h) begin
				pos_row = '0;
				row_phase = '0;
				out_row = '0;
			end else begin
				pos_row++;
				if (row_sel) begin
					out_row++;
					row_phase = sat_add(row_phase, row_step);
				end
			end
		end else begin
			pos_col++;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			flag($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic check_kept(input kept_pixel_t got);
		kept_pixel_t want;
		if (kept_q.size() == 0) begin
			flag($sformatf("kept pixel beat 0x%0h with nothing expected", got.pixel));
			return;
		end
		want = kept_q.pop_front();
		check_field("pixel_out", 32'(got.pixel), 32'(want.pixel));
		check_field("dest_column", 32'(got.col), 32'(want.col));
		check_field("dest_row", 32'(got.row), 32'(want.row));
		check_field("row_end", 32'(got.row_end), 32'(want.row_end));
		check_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
	endtask

	// sample all three channels at the rising edge
	always @(posedge clk) begin
		kept_pixel_t got;
		kept_pixel_t want;
		bit hit;
		if (arst_n) begin
			if (dst_bus.valid && dst_bus.ready) begin
				got = {dst_bus.pixel_out, dst_bus.dest_column, dst_bus.dest_row,
					dst_bus.row_end, dst_bus.frame_end};
				check_kept(got);
			end
			if (cfg_bus.valid && cfg_bus.ready)
				apply_reg(cfg_bus.index, cfg_bus.data);
			if (src_bus.valid && src_bus.ready) begin
				decimate(src_bus.pixel_in, src_bus.frame_start, hit, want);
				case (offer_chk)
					CHK_MODEL: if (hit) kept_q.push_back(want);
					CHK_TYPED: kept_q.push_back(offer_res);
					default: ;
				endcase
			end
		end
	end

	// sink side: random stalls plus one long hold-off
	initial begin
		dst_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				dst_bus.ready <= 1'b0;
			end else begin
				dst_bus.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("nearest_neighbor_downscaler: mismatch");
		$finish;
	end

	task automatic offer_pixel(input logic [nnd_pkg::PIX_W-1:0] pix, input logic fs,
		input chk_mode_t chk, input kept_pixel_t res);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			src_bus.valid <= 1'b0;
			@(negedge clk);
		end
		offer_chk = chk;
		offer_res = res;
		src_bus.valid <= 1'b1;
		src_bus.pixel_in <= pix;
		src_bus.frame_start <= fs;
		do @(posedge clk); while (!(src_bus.valid && src_bus.ready));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [nnd_pkg::CFG_IDX_W-1:0] idx,
		input logic [nnd_pkg::CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
		@(negedge clk);
	endtask

	// stop the source, wait for every kept pixel, then let the pipe empty
	task automatic settle();
		src_bus.valid <= 1'b0;
		while (kept_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic stim_row_t cfg_row(input logic [nnd_pkg::CFG_IDX_W-1:0] idx,
		input logic [nnd_pkg::CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '{ROW_CFG, idx, data, '0, 1'b0, CHK_NONE, '0};
		return r;
	endfunction

	function automatic stim_row_t pix_row(input logic [nnd_pkg::PIX_W-1:0] pix,
		input logic fs, input chk_mode_t chk);
		stim_row_t r;
		r = '{ROW_PIX, '0, '0, pix, fs, chk, '0};
		return r;
	endfunction

	function automatic stim_row_t pix_typed(input logic [nnd_pkg::PIX_W-1:0] pix,
		input logic fs, input int col, input int row, input logic re, input logic fe);
		stim_row_t r;
		r = '{ROW_PIX, '0, '0, pix, fs, CHK_TYPED,
			'{pix, nnd_pkg::COORD_W'(col), nnd_pkg::COORD_W'(row), re, fe}};
		return r;
	endfunction

	// random upper bits that the register must drop
	function automatic logic [nnd_pkg::CFG_DATA_W-1:0] with_junk(input int unsigned v,
		input int w);
		if ($urandom_range(3, 0) == 0) return v | ($urandom() << w);
		return v;
	endfunction

	task automatic program_setting(input shape_t shape);
		int unsigned sw, sh, tw, th, cs, rs;
		sw = $urandom_range(8, 1);
		sh = $urandom_range(6, 1);
		tw = $urandom_range(sw, 1);
		th = $urandom_range(sh, 1);
		cs = (sw << 16) / tw;
		rs = (sh << 16) / th;
		if ($urandom_range(1, 0)) cs = $urandom_range(cs + 65535, 65536);
		if ($urandom_range(1, 0)) rs = $urandom_range(rs + 65535, 65536);
		case (shape)
			SHAPE_FULL: begin
				sw = $urandom_range(8, 4);
				sh = $urandom_range(6, 4);
				tw = sw;
				th = sh;
				cs = 65536;
				rs = 65536;
			end
			SHAPE_WIDE: begin
				sw = ($urandom_range(2, 0) == 0) ? 4096 : $urandom_range(4096, 64);
				sh = ($urandom_range(1, 0) == 0) ? 4096 : $urandom_range(4096, 1);
				tw = ($urandom_range(2, 0) == 0) ? sw : $urandom_range(sw, 1);
				th = ($urandom_range(2, 0) == 0) ? sh : $urandom_range(sh, 1);
				cs = ($urandom_range(3, 0) == 0) ? 32'h1000_0000 : (sw << 16) / tw;
				rs = ($urandom_range(3, 0) == 0) ? 32'h1000_0000 : (sh << 16) / th;
			end
			SHAPE_BAD: begin
				// break at least one geometry rule
				case ($urandom_range(5, 0))
					0: if ($urandom_range(1, 0)) sw = 0; else sh = 0;
					1: if ($urandom_range(1, 0)) tw = 0; else th = 0;
					2: if ($urandom_range(1, 0)) sw = $urandom_range(8191, 4097);
						else sh = $urandom_range(8191, 4097);
					3: if ($urandom_range(1, 0)) tw = sw + $urandom_range(3, 1);
						else th = sh + $urandom_range(3, 1);
					4: cs = $urandom_range(65535, 0);
					default: rs = $urandom_range(65535, 0);
				endcase
			end
			default: ;
		endcase
		write_reg(nnd_pkg::REG_TARGET_WIDTH, with_junk(tw, nnd_pkg::REG_W));
		write_reg(nnd_pkg::REG_SOURCE_WIDTH, with_junk(sw, nnd_pkg::REG_W));
		write_reg(nnd_pkg::REG_TARGET_HEIGHT, with_junk(th, nnd_pkg::REG_W));
		write_reg(nnd_pkg::REG_SOURCE_HEIGHT, with_junk(sh, nnd_pkg::REG_W));
		write_reg(nnd_pkg::REG_COLUMN_STEP, with_junk(cs, nnd_pkg::STEP_W));
		write_reg(nnd_pkg::REG_ROW_STEP, with_junk(rs, nnd_pkg::STEP_W));
		if ($urandom_range(9, 0) == 0)
			write_reg($urandom_range(1, 0) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
	endtask

	// frames with random content, some truncated, some restarted
	task automatic send_frames(input shape_t shape, output int sent);
		int frames, len;
		sent = 0;
		if (shape == SHAPE_WIDE || shape == SHAPE_BAD) begin
			len = (shape == SHAPE_WIDE) ? $urandom_range(60, 20) : $urandom_range(12, 4);
			for (int i = 0; i < len; i++)
				offer_pixel(nnd_pkg::PIX_W'($urandom()),
					(i == 0) || ($urandom_range(49, 0) == 0), CHK_MODEL, '0);
			sent = len;
			return;
		end
		frames = (shape == SHAPE_FULL) ? 4 : $urandom_range(4, 1);
		for (int f = 0; f < frames; f++) begin
			len = int'(src_w) * int'(src_h);
			if ($urandom_range(99, 0) < 15) len = $urandom_range(len, 1);
			for (int i = 0; i < len; i++)
				offer_pixel(nnd_pkg::PIX_W'($urandom()),
					(i == 0) ? ($urandom_range(9, 0) != 0) : ($urandom_range(99, 0) < 3),
					CHK_MODEL, '0);
			sent += len;
		end
	endtask

	// stimulus
	initial begin
		int sent, rand_items;
		int unsigned pick;
		shape_t shape;
		bit in_last_third;

		src_bus.valid = 1'b0;
		src_bus.pixel_in = '0;
		src_bus.frame_start = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		arst_n = 1'b0;
		rand_items = 0;
		in_last_third = 1'b0;

		dir_rows = '{
			// reset geometry keeps every pixel as a whole frame
			pix_typed(16'h0000, 1'b1, 0, 0, 1'b1, 1'b1),
			pix_typed(16'hFFFF, 1'b0, 0, 0, 1'b1, 1'b1),
			// largest sizes at unit steps
			cfg_row(nnd_pkg::REG_SOURCE_WIDTH, 32'd4096),
			cfg_row(nnd_pkg::REG_SOURCE_HEIGHT, 32'd4096),
			cfg_row(nnd_pkg::REG_TARGET_WIDTH, 32'd4096),
			cfg_row(nnd_pkg::REG_TARGET_HEIGHT, 32'd4096),
			pix_typed(16'h1234, 1'b1, 0, 0, 1'b0, 1'b0),
			pix_typed(16'hABCD, 1'b0, 1, 0, 1'b0, 1'b0),
			pix_row(16'h5555, 1'b0, CHK_MODEL),
			pix_row(16'hAAAA, 1'b0, CHK_MODEL),
			// shrink mid row: counters past the new width wrap the row
			cfg_row(nnd_pkg::REG_TARGET_WIDTH, 32'd2),
			cfg_row(nnd_pkg::REG_SOURCE_WIDTH, 32'd2),
			pix_row(16'h0F0F, 1'b0, CHK_MODEL),
			pix_row(16'hF0F0, 1'b0, CHK_MODEL),
			// column step of 4096.0: second column lies beyond the source
			cfg_row(nnd_pkg::REG_COLUMN_STEP, 32'h1000_0000),
			pix_typed(16'h0001, 1'b1, 0, 0, 1'b0, 1'b0),
			pix_row(16'h8000, 1'b0, CHK_NONE),
			pix_row(16'h00FF, 1'b0, CHK_MODEL),
			// upper bits dropped: column step back to 1.0
			cfg_row(nnd_pkg::REG_COLUMN_STEP, 32'hE001_0000),
			// enlarging row step is rejected
			cfg_row(nnd_pkg::REG_ROW_STEP, 32'h0000_FFFF),
			pix_row(16'h7FFF, 1'b1, CHK_NONE),
			// all-ones row step takes the row accumulator to its largest value
			cfg_row(nnd_pkg::REG_ROW_STEP, 32'hFFFF_FFFF),
			pix_row(16'h3C3C, 1'b1, CHK_MODEL),
			pix_row(16'hC3C3, 1'b0, CHK_MODEL),
			pix_row(16'h0FF0, 1'b0, CHK_MODEL),
			// zero and oversized source width, zero source height
			cfg_row(nnd_pkg::REG_SOURCE_WIDTH, 32'd0),
			pix_row(16'h5A5A, 1'b1, CHK_NONE),
			cfg_row(nnd_pkg::REG_SOURCE_WIDTH, 32'd5000),
			pix_row(16'hA5A5, 1'b1, CHK_NONE),
			cfg_row(nnd_pkg::REG_SOURCE_WIDTH, 32'h0000_1FFF),
			pix_row(16'h6666, 1'b0, CHK_NONE),
			cfg_row(nnd_pkg::REG_SOURCE_WIDTH, 32'd2),
			cfg_row(nnd_pkg::REG_SOURCE_HEIGHT, 32'd0),
			pix_row(16'h9999, 1'b1, CHK_NONE),
			// writes to unknown indexes change nothing
			cfg_row(REG_SPARE_6, 32'hDEAD_BEEF),
			cfg_row(REG_SPARE_7, 32'h0000_0003),
			// target taller than source
			cfg_row(nnd_pkg::REG_SOURCE_HEIGHT, 32'd1),
			pix_row(16'h1111, 1'b1, CHK_NONE),
			cfg_row(nnd_pkg::REG_TARGET_HEIGHT, 32'd1),
			pix_typed(16'h2222, 1'b1, 0, 0, 1'b0, 1'b0),
			pix_typed(16'h4444, 1'b0, 1, 0, 1'b1, 1'b1)
		};

		// reset
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// sender idles often, sink stalls most cycles
		src_idle_pct = 27;
		sink_idle_pct <= 84;

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (i > 0 && dir_rows[i-1].kind == ROW_PIX) settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				if (i > 0 && dir_rows[i-1].kind == ROW_CFG) cfg_bus.valid <= 1'b0;
				offer_pixel(dir_rows[i].pix, dir_rows[i].fs, dir_rows[i].chk,
					dir_rows[i].res);
			end
		end

		// random settings, idle pattern changes by thirds
		while (rand_items < RAND_ITEMS) begin
			settle();
			if (rand_items < RAND_ITEMS / 3) begin
				src_idle_pct = 27;
				sink_idle_pct <= 84;
			end else if (rand_items < 2 * RAND_ITEMS / 3) begin
				src_idle_pct = 84;
				sink_idle_pct <= 27;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct <= 0;
			end

			pick = $urandom_range(99, 0);
			if (pick < 60)
				shape = SHAPE_NORMAL;
			else if (pick < 70)
				shape = SHAPE_FULL;
			else if (pick < 82)
				shape = SHAPE_WIDE;
			else
				shape = SHAPE_BAD;
			// first setting of the last third: back-pressure fills the pipe
			if (!in_last_third && rand_items >= 2 * RAND_ITEMS / 3) begin
				shape = SHAPE_FULL;
				in_last_third = 1'b1;
			end

			program_setting(shape);
			cfg_bus.valid <= 1'b0;
			if (in_last_third) hold_req <= 1'b1;
			send_frames(shape, sent);
			if (geometry_ok()) rand_items += sent;
		end

		settle();
		if (err_cnt == 0) begin
			$display("nearest_neighbor_downscaler: match");
		end else begin
			$display("nearest_neighbor_downscaler: mismatch");
		end
		$finish;
	end

endmodule
